@@ hw/rtl/source_token_scanner_core_assert.svh @@
// Assertion macros used by the checker file.
`ifndef SOURCE_TOKEN_SCANNER_CORE_ASSERT_SVH
`define SOURCE_TOKEN_SCANNER_CORE_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define STS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check an implication on every clock edge outside reset.
`define STS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/sts_pkg.sv @@
`timescale 1ns / 1ps
package sts_pkg;

  localparam int unsigned MaxLexemeLen = 255;
  localparam int unsigned KeywordBytes = 6;

  typedef enum logic [4:0] {
    StStart   = 5'd0,  StStar    = 5'd1,  StPlus    = 5'd2,  StMinus   = 5'd3,
    StSlash   = 5'd4,  StCmt     = 5'd5,  StCmtStar = 5'd6,  StColon   = 5'd7,
    StEq      = 5'd8,  StAmp     = 5'd9,  StBar     = 5'd10, StGt      = 5'd11,
    StLt      = 5'd12, StUnder   = 5'd13, StIdent   = 5'd14, StDot     = 5'd15,
    StFrac1   = 5'd16, StDec     = 5'd17, StPoint   = 5'd18, StFrac2   = 5'd19,
    StZero    = 5'd20, StBin     = 5'd21, StOct     = 5'd22, StDuo     = 5'd23,
    StHex     = 5'd24
  } scan_state_e;

  localparam logic [5:0] KindId  = 6'd31;
  localparam logic [5:0] KindLit = 6'd32;
  localparam logic [5:0] KindEnd = 6'd49;

  localparam logic [1:0] LitNone = 2'd0;
  localparam logic [1:0] LitInt  = 2'd1;
  localparam logic [1:0] LitFrac = 2'd2;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_input;
  } sts_in_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [1:0]  literal_kind;
    logic [7:0]  lexeme_length;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic        lex_error;
    logic        last;
  } sts_out_t;

  // One emitted token and its presence flag, passed from the step logic.
  typedef struct packed {
    logic     valid;
    sts_out_t tok;
  } sts_res_t;

  typedef logic [KeywordBytes-1:0][7:0] kw_buf_t;

  function automatic logic [5:0] kw_lookup(input kw_buf_t b, input logic [7:0] len);
    logic [47:0] s;
    logic [5:0]  k;
    s = {b[0], b[1], b[2], b[3], b[4], b[5]};
    k = KindId;
    unique case (len)
      8'd2: begin
        if (s[47:32] == "or") k = 6'd16;
        else if (s[47:32] == "do") k = 6'd42;
        else if (s[47:32] == "if") k = 6'd43;
      end
      8'd3: begin
        if (s[47:24] == "int") k = 6'd34;
        else if (s[47:24] == "not") k = 6'd39;
        else if (s[47:24] == "and") k = 6'd14;
        else if (s[47:24] == "for") k = 6'd41;
      end
      8'd4: begin
        if (s[47:16] == "char") k = 6'd36;
        else if (s[47:16] == "bool") k = 6'd38;
        else if (s[47:16] == "then") k = 6'd44;
        else if (s[47:16] == "else") k = 6'd45;
        else if (s[47:16] == "elif") k = 6'd46;
        else if (s[47:16] == "read") k = 6'd47;
      end
      8'd5: begin
        if (s[47:8] == "const") k = 6'd33;
        else if (s[47:8] == "while") k = 6'd40;
        else if (s[47:8] == "input") k = 6'd47;
        else if (s[47:8] == "print") k = 6'd48;
        else if (s[47:8] == "write") k = 6'd48;
      end
      8'd6: begin
        if (s == "double") k = 6'd35;
        else if (s == "string") k = 6'd37;
      end
      default: k = KindId;
    endcase
    return k;
  endfunction

endpackage

@@ hw/rtl/source_token_scanner_core.sv @@
`timescale 1ns / 1ps
// Channel | dir | handshake          | payload
// in      | in  | in_valid_i/stall_o | sts_in_t  (ch, end_of_input)
// out     | out | out_valid_o/stall_i| sts_out_t (token fields, lex_error, last)
// One byte per cycle while in_stall_o is low; the lexer step and keyword compare are combinational.
// Results pass through a two-entry queue; input stalls while it cannot take two.
// Reset clears state to start, line 1, column 0; an error halts until reset.
// Halted: input is still taken and dropped.
module source_token_scanner_core import sts_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  sts_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output sts_out_t out_data_o
);

  scan_state_e st_q, st_d;
  kw_buf_t     kw_q, kw_d;
  logic [7:0]  cnt_q, cnt_d;
  logic        kwl_q, kwl_d, halt_q, halt_d;
  logic [15:0] line_q, line_d, col_q, col_d, tl_q, tl_d, tc_q, tc_d;
  sts_res_t    r0, r1;
  logic        room, take;

  assign in_stall_o = !room && !halt_q;
  assign take = in_valid_i && !in_stall_o && !halt_q;

  sts_step u_step (
    .in_i(in_data_i), .st_i(st_q), .kw_i(kw_q), .cnt_i(cnt_q), .kwl_i(kwl_q),
    .line_i(line_q), .col_i(col_q), .tline_i(tl_q), .tcol_i(tc_q),
    .st_o(st_d), .kw_o(kw_d), .cnt_o(cnt_d), .kwl_o(kwl_d),
    .line_o(line_d), .col_o(col_d), .tline_o(tl_d), .tcol_o(tc_d),
    .halt_o(halt_d), .r0_o(r0), .r1_o(r1)
  );

  sts_out_queue u_queue (
    .clk_i, .rst_ni, .push_i(take), .r0_i(r0), .r1_i(r1), .room_o(room),
    .valid_o(out_valid_o), .data_o(out_data_o), .stall_i(out_stall_i)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StStart; cnt_q <= '0; kwl_q <= 1'b0; halt_q <= 1'b0;
      line_q <= 16'd1; col_q <= '0; tl_q <= 16'd1; tc_q <= '0;
    end else if (take) begin
      st_q <= st_d; cnt_q <= cnt_d; kwl_q <= kwl_d; halt_q <= halt_d;
      line_q <= line_d; col_q <= col_d; tl_q <= tl_d; tc_q <= tc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) kw_q <= kw_d;
  end

endmodule

@@ hw/rtl/sts_step.sv @@
`timescale 1ns / 1ps
// Combinational lexer step: one byte (possibly rescanned) or end marker.
module sts_step import sts_pkg::*; (
  input  sts_in_t     in_i,
  input  scan_state_e st_i,
  input  kw_buf_t     kw_i,
  input  logic [7:0]  cnt_i,
  input  logic        kwl_i,
  input  logic [15:0] line_i,
  input  logic [15:0] col_i,
  input  logic [15:0] tline_i,
  input  logic [15:0] tcol_i,
  output scan_state_e st_o,
  output kw_buf_t     kw_o,
  output logic [7:0]  cnt_o,
  output logic        kwl_o,
  output logic [15:0] line_o,
  output logic [15:0] col_o,
  output logic [15:0] tline_o,
  output logic [15:0] tcol_o,
  output logic        halt_o,
  output sts_res_t    r0_o,
  output sts_res_t    r1_o
);

  logic [8:0] c;
  logic [15:0] colb;
  // state after first pass, before rescan
  scan_state_e s1;
  kw_buf_t kw1;
  logic [7:0] cnt1;
  logic kwl1, again, err1, acc1;
  logic [5:0] kind1;
  logic [1:0] lit1;
  logic [15:0] tl1, tc1;
  scan_state_e s2;
  kw_buf_t kw2;
  logic [7:0] cnt2;
  logic kwl2, err2, acc2;
  logic [5:0] kind2;
  logic [1:0] lit2;
  logic [15:0] tl2, tc2;

  function automatic logic is_dig(input logic [8:0] x);
    return x >= 9'h30 && x <= 9'h39;
  endfunction
  function automatic logic is_low(input logic [8:0] x);
    return x >= 9'h61 && x <= 9'h7a;
  endfunction
  function automatic logic is_blank(input logic [8:0] x);
    return x == 9'h20 || x == 9'h09 || x == 9'h0a || x == 9'h0d || x == 9'h0b || x == 9'h0c;
  endfunction

  // One automaton step. beg restarts the lexeme; add appends.
  task automatic scan(
    input  logic [8:0]  x,
    input  scan_state_e si,
    input  kw_buf_t     ki,
    input  logic [7:0]  ni,
    input  logic        li,
    input  logic [15:0] tli,
    input  logic [15:0] tci,
    output scan_state_e so,
    output kw_buf_t     ko,
    output logic [7:0]  no,
    output logic        lo,
    output logic [15:0] tlo,
    output logic [15:0] tco,
    output logic        acc,
    output logic        err,
    output logic [5:0]  kind,
    output logic [1:0]  lit,
    output logic        resc
  );
    logic add, beg;
    logic [5:0] ik;
    so = si; ko = ki; no = ni; lo = li; tlo = tli; tco = tci;
    acc = 1'b0; err = 1'b0; kind = '0; lit = LitNone; resc = 1'b0;
    add = 1'b0; beg = 1'b0;
    ik = li ? KindId : kw_lookup(ki, ni);
    unique case (si)
      StStart: begin
        so = StStart;
        if (is_blank(x)) begin
        end else if (is_low(x)) begin beg = 1'b1; so = StIdent; end
        else if (x >= 9'h31 && x <= 9'h39) begin beg = 1'b1; so = StDec; end
        else begin
          beg = 1'b1;
          unique case (x)
            9'h2a: so = StStar;   9'h2b: so = StPlus;  9'h2d: so = StMinus;
            9'h2f: so = StSlash;  9'h3a: so = StColon; 9'h3d: so = StEq;
            9'h26: so = StAmp;    9'h7c: so = StBar;   9'h3e: so = StGt;
            9'h3c: so = StLt;     9'h5f: so = StUnder; 9'h2e: so = StDot;
            9'h30: so = StZero;
            9'h25: begin acc = 1'b1; kind = 6'd22; end
            9'h3f: begin acc = 1'b1; kind = 6'd23; end
            9'h3b: begin acc = 1'b1; kind = 6'd24; end
            9'h28: begin acc = 1'b1; kind = 6'd25; end
            9'h29: begin acc = 1'b1; kind = 6'd26; end
            9'h5b: begin acc = 1'b1; kind = 6'd27; end
            9'h5d: begin acc = 1'b1; kind = 6'd28; end
            9'h7b: begin acc = 1'b1; kind = 6'd29; end
            9'h7d: begin acc = 1'b1; kind = 6'd30; end
            default: beg = 1'b0;
          endcase
        end
      end
      StStar: begin
        acc = 1'b1; so = StStart;
        if (x == 9'h3d) begin add = 1'b1; kind = 6'd1; end
        else if (x == 9'h2a) begin add = 1'b1; kind = 6'd2; end
        else begin kind = 6'd0; resc = 1'b1; end
      end
      StPlus: begin
        acc = 1'b1; so = StStart;
        if (x == 9'h2b) begin add = 1'b1; kind = 6'd4; end
        else if (x == 9'h3d) begin add = 1'b1; kind = 6'd5; end
        else begin kind = 6'd3; resc = 1'b1; end
      end
      StMinus: begin
        acc = 1'b1; so = StStart;
        if (x == 9'h2d) begin add = 1'b1; kind = 6'd7; end
        else if (x == 9'h3d) begin add = 1'b1; kind = 6'd8; end
        else begin kind = 6'd6; resc = 1'b1; end
      end
      StSlash: begin
        if (x == 9'h2a) begin so = StCmt; no = '0; end
        else begin
          acc = 1'b1; so = StStart;
          if (x == 9'h3d) begin add = 1'b1; kind = 6'd10; end
          else begin kind = 6'd9; resc = 1'b1; end
        end
      end
      StCmt: if (x == 9'h2a) so = StCmtStar;
      StCmtStar: begin
        if (x == 9'h2f) so = StStart;
        else if (x != 9'h2a) so = StCmt;
      end
      StColon: begin
        so = StStart;
        if (x == 9'h3d) begin add = 1'b1; acc = 1'b1; kind = 6'd11; end
        else err = 1'b1;
      end
      StEq: begin
        acc = 1'b1; so = StStart;
        if (x == 9'h3d) begin add = 1'b1; kind = 6'd12; end
        else begin kind = 6'd11; resc = 1'b1; end
      end
      StAmp: begin
        acc = 1'b1; so = StStart;
        if (x == 9'h26) begin add = 1'b1; kind = 6'd14; end
        else begin kind = 6'd13; resc = 1'b1; end
      end
      StBar: begin
        acc = 1'b1; so = StStart;
        if (x == 9'h7c) begin add = 1'b1; kind = 6'd16; end
        else begin kind = 6'd15; resc = 1'b1; end
      end
      StGt: begin
        acc = 1'b1; so = StStart;
        if (x == 9'h3d) begin add = 1'b1; kind = 6'd18; end
        else begin kind = 6'd17; resc = 1'b1; end
      end
      StLt: begin
        acc = 1'b1; so = StStart;
        if (x == 9'h3e) begin add = 1'b1; kind = 6'd20; end
        else if (x == 9'h3d) begin add = 1'b1; kind = 6'd21; end
        else begin kind = 6'd19; resc = 1'b1; end
      end
      StUnder: begin
        if (x == 9'h5f) add = 1'b1;
        else if (is_low(x) || is_dig(x)) begin add = 1'b1; so = StIdent; end
        else begin err = 1'b1; so = StStart; end
      end
      StIdent: begin
        if (x == 9'h5f || is_low(x) || is_dig(x)) add = 1'b1;
        else begin acc = 1'b1; kind = ik; resc = 1'b1; so = StStart; end
      end
      StDot, StPoint: begin
        if (is_dig(x)) begin add = 1'b1; so = (si == StDot) ? StFrac1 : StFrac2; end
        else begin err = 1'b1; so = StStart; end
      end
      StFrac1, StFrac2: begin
        if (is_dig(x)) add = 1'b1;
        else begin acc = 1'b1; kind = KindLit; lit = LitFrac; resc = 1'b1; so = StStart; end
      end
      StDec: begin
        if (is_dig(x)) add = 1'b1;
        else if (x == 9'h2e) begin add = 1'b1; so = StPoint; end
        else begin acc = 1'b1; kind = KindLit; lit = LitInt; resc = 1'b1; so = StStart; end
      end
      StZero: begin
        add = 1'b1;
        if (x == 9'h62) so = StBin;
        else if (x == 9'h6f) so = StOct;
        else if (x == 9'h64) so = StDuo;
        else if (x == 9'h78) so = StHex;
        else if (is_dig(x)) so = StDec;
        else begin
          add = 1'b0; acc = 1'b1; kind = KindLit; lit = LitInt; resc = 1'b1;
          so = StStart;
        end
      end
      StBin, StOct, StDuo, StHex: begin
        if ((si == StBin && (x == 9'h30 || x == 9'h31)) ||
            (si == StOct && x >= 9'h30 && x <= 9'h37) ||
            (si == StDuo && (is_dig(x) || x == 9'h64 || x == 9'h65 ||
                             x == 9'h44 || x == 9'h45)) ||
            (si == StHex && (is_dig(x) || (x >= 9'h61 && x <= 9'h66) ||
                             (x >= 9'h41 && x <= 9'h46))))
          add = 1'b1;
        else begin acc = 1'b1; kind = KindLit; lit = LitInt; resc = 1'b1; so = StStart; end
      end
      default: so = StStart;
    endcase
    if (beg) begin
      no = '0; lo = 1'b0; tlo = line_i; tco = colb;
    end
    if (beg || add) begin
      if (no < 8'(KeywordBytes)) ko[no[2:0]] = x[7:0];
      else lo = 1'b1;
      if (no < 8'(MaxLexemeLen)) no = no + 8'd1;
      else lo = 1'b1;
    end
    if (acc || err) so = StStart;
  endtask

  always_comb begin
    c = in_i.end_of_input ? 9'h100 : {1'b0, in_i.ch};
    colb = (in_i.end_of_input || col_i == 16'hffff) ? col_i : col_i + 16'd1;
    scan(c, st_i, kw_i, cnt_i, kwl_i, tline_i, tcol_i,
         s1, kw1, cnt1, kwl1, tl1, tc1, acc1, err1, kind1, lit1, again);
    scan(c, s1, kw1, cnt1, kwl1, tl1, tc1,
         s2, kw2, cnt2, kwl2, tl2, tc2, acc2, err2, kind2, lit2, /* unused */ kwl_o);
    // the second scan is from start, so it never asks for a rescan
    kwl_o = (again && !err1 && !in_i.end_of_input) ? kwl2 : kwl1;
    r0_o = '0; r1_o = '0;
    r0_o.valid = acc1 || err1;
    r0_o.tok.token_kind = err1 ? 6'd0 : kind1;
    r0_o.tok.literal_kind = err1 ? LitNone : lit1;
    r0_o.tok.lex_error = err1;
    r0_o.tok.lexeme_length = err1 ? cnt_i : cnt1;
    r0_o.tok.start_line = tl1;
    r0_o.tok.start_column = tc1;
    halt_o = err1;
    st_o = s1; kw_o = kw1; cnt_o = cnt1; tline_o = tl1; tcol_o = tc1;
    if (in_i.end_of_input) begin
      st_o = StStart;
      if (!err1) begin
        r1_o.valid = 1'b1;
        r1_o.tok.token_kind = KindEnd;
        r1_o.tok.start_line = line_i;
        r1_o.tok.start_column = col_i;
      end
    end else if (again && !err1) begin
      st_o = s2; kw_o = kw2; cnt_o = cnt2; tline_o = tl2; tcol_o = tc2;
      halt_o = err2;
      r1_o.valid = acc2 || err2;
      r1_o.tok.token_kind = err2 ? 6'd0 : kind2;
      r1_o.tok.literal_kind = err2 ? LitNone : lit2;
      r1_o.tok.lex_error = err2;
      r1_o.tok.lexeme_length = cnt2;
      r1_o.tok.start_line = tl2;
      r1_o.tok.start_column = tc2;
    end
    line_o = line_i;
    col_o = colb;
    if (!in_i.end_of_input && (in_i.ch == 8'h0a || in_i.ch == 8'h0d)) begin
      if (line_i != 16'hffff) line_o = line_i + 16'd1;
      col_o = '0;
    end
    if (r1_o.valid) r1_o.tok.last = 1'b1;
    else r0_o.tok.last = 1'b1;
  end

endmodule

@@ hw/rtl/sts_out_queue.sv @@
`timescale 1ns / 1ps
// Two-entry result queue; takes up to two results per cycle.
module sts_out_queue import sts_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  sts_res_t r0_i,
  input  sts_res_t r1_i,
  output logic     room_o,
  output logic     valid_o,
  output sts_out_t data_o,
  input  logic     stall_i
);

  sts_out_t   mem_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       rd_q;
  logic       pop;
  logic [1:0] npush;
  logic [1:0] rem;

  assign pop     = valid_o && !stall_i;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rd_q];
  // accept only when both slots would be free after this cycle's pop
  assign room_o  = cnt_q == 2'd0 || (cnt_q == 2'd1 && pop);
  assign npush   = push_i ? 2'(r0_i.valid) + 2'(r1_i.valid) : 2'd0;
  assign rem     = cnt_q - 2'(pop);
  assign cnt_d   = rem + npush;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      rd_q  <= rd_q ^ pop;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      if (r0_i.valid) mem_q[rd_q ^ pop ^ rem[0]] <= r0_i.tok;
      if (r1_i.valid) mem_q[rd_q ^ pop ^ rem[0] ^ r0_i.valid] <= r1_i.tok;
    end
  end

endmodule

@@ hw/rtl/sts_checker.sv @@
`timescale 1ns / 1ps
`include "source_token_scanner_core_assert.svh"
module sts_checker import sts_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input sts_out_t out_data_o
);
  `STS_ASSERT_IMP(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, ##1 $stable(out_data_o), "stalled result changed")
  `STS_ASSERT_IMP(a_err_last, clk_i, rst_ni, out_valid_o && out_data_o.lex_error, out_data_o.last, "error not last")
  `STS_ASSERT_IMP(a_end_len, clk_i, rst_ni, out_valid_o && out_data_o.token_kind == KindEnd, out_data_o.lexeme_length == 8'd0 && out_data_o.last, "bad end token")
  `STS_ASSERT_IMP(a_line, clk_i, rst_ni, out_valid_o, out_data_o.start_line != 16'd0, "line zero")
  `STS_ASSERT_IMP(a_stall_busy, clk_i, rst_ni, in_valid_i && in_stall_o, out_valid_o, "request stalled with no result waiting")
endmodule

bind source_token_scanner_core sts_checker u_sts_checker (.*);
